// ===== design/pbb_pkg.sv =====
// Shared types and constants for the parallel biquad bank.
// Sequencer step encoding, register map and internal word widths.
// No dependencies.
package pbb_pkg;

	// state words are Q4.27, 32 bits
	localparam int STATE_W    = 32;
	localparam int STATE_FRAC = 27;
	// coefficient lane pitch inside a 64-bit register
	localparam int LANE_BITS  = 16;
	localparam int CFG_W      = 64;
	localparam int CFG_ADDR_W = 6;
	// working width of the shared adder and the output accumulator
	localparam int ACC_W      = 40;
	localparam int SUM_W      = 36;

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_B0 = 3'd0;
	localparam reg_idx_t REG_B1 = 3'd1;
	localparam reg_idx_t REG_B2 = 3'd2;
	localparam reg_idx_t REG_A1 = 3'd3;
	localparam reg_idx_t REG_A2 = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_B0,
		ST_B1,
		ST_A1,
		ST_B2,
		ST_A2,
		ST_UPD,
		ST_DONE
	} step_t;

	function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-STATE_W:0] top;
		top = v[ACC_W-1:STATE_W-1];
		if (top == '0 || top == '1) begin
			return v[STATE_W-1:0];
		end else if (v[ACC_W-1]) begin
			return {1'b1, {(STATE_W-1){1'b0}}};
		end else begin
			return {1'b0, {(STATE_W-1){1'b1}}};
		end
	endfunction

endpackage

// ===== design/parallel_biquad_bank_tdf2.sv =====
// Bank of transposed direct form II biquads in parallel form, one shared multiplier.
// A beat is accepted only in idle, and the next one only after the result of the
// last has been loaded into the output register and the sequencer is back in idle.
// Five products per section go through the single multiplier,
// plus one step to write back the second delay word; one step forms the output.
// Reset clears the coefficient registers, all delay words and the control state.
module parallel_biquad_bank_tdf2 #(
	parameter int SECTION_COUNT = 4,
	parameter int SAMPLE_BITS   = 16,
	parameter int COEF_BITS     = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [pbb_pkg::CFG_ADDR_W-1:0]       paddr,
	input  logic [pbb_pkg::CFG_W-1:0]            pwdata,
	output logic [pbb_pkg::CFG_W-1:0]            prdata,
	output logic                                 pready,
	// input stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,  // [SAMPLE_BITS-1:0] sample_in
	input  logic                                 s_tlast,  // frame_end
	// output stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_tdata,  // [SAMPLE_BITS-1:0] filtered_sample
	output logic                                 m_tlast   // frame_end_out
);
	import pbb_pkg::*;

	localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int SEC_W  = (SECTION_COUNT > 1) ? $clog2(SECTION_COUNT) : 1;
	localparam int MUL_W  = STATE_W + COEF_BITS;
	localparam int XFRAC  = (SAMPLE_BITS - 1) + (COEF_BITS - 3);
	localparam int XSHR   = (XFRAC > STATE_FRAC) ? XFRAC - STATE_FRAC : 0;
	localparam int XSHL   = (XFRAC < STATE_FRAC) ? STATE_FRAC - XFRAC : 0;
	localparam int YSH    = COEF_BITS - 3;
	localparam int OSH    = STATE_FRAC - (SAMPLE_BITS - 1);

	// control
	step_t             state_q, state_d;
	logic [SEC_W-1:0]  sec_q;
	logic              out_valid_q;
	logic              out_free;
	logic              in_acc;
	logic              out_load;

	// coefficients
	logic [CFG_W-1:0]  b0_q, b1_q, b2_q, a1_q, a2_q;
	logic              cfg_wr;

	// datapath
	logic signed [SAMPLE_BITS-1:0]  x_q;
	logic                           last_q;
	logic signed [STATE_W-1:0]      w1_q [SECTION_COUNT];
	logic signed [STATE_W-1:0]      w2_q [SECTION_COUNT];
	logic signed [STATE_W-1:0]      y_q;
	logic signed [ACC_W-1:0]        acc_q;
	logic signed [SUM_W-1:0]        sum_q;
	logic signed [MUL_W-1:0]        prod_q;
	logic [SAMPLE_BITS-1:0]         out_data_q;
	logic                           out_last_q;

	// step decode
	reg_idx_t  coef_sel;
	logic      mul_use_y;
	logic      add_from_acc;
	logic      add_sub;
	logic      add_w1, add_w2;
	logic      y_en, acc_en, w1_en, w2_en;

	logic [CFG_W-1:0]               coef_word;
	logic signed [COEF_BITS-1:0]    coef_val;
	logic signed [STATE_W-1:0]      mul_a;
	logic signed [63:0]             prod_wide, tsx_wide, tsy_wide;
	logic signed [ACC_W-1:0]        tsx, tsy, add_a, add_b, add_res;
	logic signed [SUM_W-1:0]        sum_shift;
	logic [SUM_W-SAMPLE_BITS:0]     sum_top;
	logic [SAMPLE_BITS-1:0]         out_sat;

	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign out_load = (state_q == ST_DONE) && out_free;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (reg_idx_t'(paddr[5:3]))
			REG_B0:  prdata = b0_q;
			REG_B1:  prdata = b1_q;
			REG_B2:  prdata = b2_q;
			REG_A1:  prdata = a1_q;
			REG_A2:  prdata = a2_q;
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q <= '0;
			b1_q <= '0;
			b2_q <= '0;
			a1_q <= '0;
			a2_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[5:3]))
				REG_B0:  b0_q <= pwdata;
				REG_B1:  b1_q <= pwdata;
				REG_B2:  b2_q <= pwdata;
				REG_A1:  a1_q <= pwdata;
				REG_A2:  a2_q <= pwdata;
				default: ;
			endcase
		end
	end

	// ---------------- sequencer ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_acc) state_d = ST_B0;
			ST_B0:   state_d = ST_B1;
			ST_B1:   state_d = ST_A1;
			ST_A1:   state_d = ST_B2;
			ST_B2:   state_d = ST_A2;
			ST_A2:   state_d = ST_UPD;
			ST_UPD: begin
				if (sec_q == SEC_W'(SECTION_COUNT - 1)) state_d = ST_DONE;
				else state_d = ST_B0;
			end
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// per step: which product to form and what the adder does with the last one
	always_comb begin
		s_tready     = 1'b0;
		coef_sel     = REG_B0;
		mul_use_y    = 1'b0;
		add_from_acc = 1'b0;
		add_sub      = 1'b0;
		add_w1       = 1'b0;
		add_w2       = 1'b0;
		y_en         = 1'b0;
		acc_en       = 1'b0;
		w1_en        = 1'b0;
		w2_en        = 1'b0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_B0:   coef_sel = REG_B0;
			ST_B1: begin
				// y = b0*x + w1
				coef_sel = REG_B1;
				add_w1   = 1'b1;
				y_en     = 1'b1;
			end
			ST_A1: begin
				// acc = b1*x + w2
				coef_sel  = REG_A1;
				mul_use_y = 1'b1;
				add_w2    = 1'b1;
				acc_en    = 1'b1;
			end
			ST_B2: begin
				// w1 = acc - a1*y
				coef_sel     = REG_B2;
				add_from_acc = 1'b1;
				add_sub      = 1'b1;
				w1_en        = 1'b1;
			end
			ST_A2: begin
				// acc = b2*x
				coef_sel  = REG_A2;
				mul_use_y = 1'b1;
				acc_en    = 1'b1;
			end
			ST_UPD: begin
				// w2 = acc - a2*y
				add_from_acc = 1'b1;
				add_sub      = 1'b1;
				w2_en        = 1'b1;
			end
			ST_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sec_q   <= '0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				sec_q <= '0;
			end else if (state_q == ST_UPD && state_d == ST_B0) begin
				sec_q <= sec_q + 1'b1;
			end
		end
	end

	// ---------------- shared multiplier ----------------
	always_comb begin
		unique case (coef_sel)
			REG_B0:  coef_word = b0_q;
			REG_B1:  coef_word = b1_q;
			REG_B2:  coef_word = b2_q;
			REG_A1:  coef_word = a1_q;
			REG_A2:  coef_word = a2_q;
			default: coef_word = '0;
		endcase
	end

	assign coef_val = coef_word[LANE_BITS*sec_q +: COEF_BITS];
	assign mul_a    = mul_use_y ? y_q
		: {{(STATE_W-SAMPLE_BITS){x_q[SAMPLE_BITS-1]}}, x_q};

	always_ff @(posedge clk) begin
		prod_q <= mul_a * coef_val;
	end

	// ---------------- shared adder ----------------
	// products of x and of y carry different fraction counts; both land on Q4.27
	assign prod_wide = {{(64-MUL_W){prod_q[MUL_W-1]}}, prod_q};
	assign tsx_wide  = (prod_wide <<< XSHL) >>> XSHR;
	assign tsy_wide  = prod_wide >>> YSH;
	assign tsx       = tsx_wide[ACC_W-1:0];
	assign tsy       = tsy_wide[ACC_W-1:0];

	always_comb begin
		add_a = add_from_acc ? acc_q : tsx;
		if (add_sub) begin
			add_b = tsy;
		end else if (add_w1) begin
			add_b = {{(ACC_W-STATE_W){w1_q[sec_q][STATE_W-1]}}, w1_q[sec_q]};
		end else if (add_w2) begin
			add_b = {{(ACC_W-STATE_W){w2_q[sec_q][STATE_W-1]}}, w2_q[sec_q]};
		end else begin
			add_b = '0;
		end
		add_res = add_sub ? add_a - add_b : add_a + add_b;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q    <= s_tdata[SAMPLE_BITS-1:0];
			last_q <= s_tlast;
			sum_q  <= '0;
		end
		if (y_en) y_q <= sat_state(add_res);
		if (acc_en) acc_q <= add_res;
		if (w2_en) sum_q <= sum_q + {{(SUM_W-STATE_W){y_q[STATE_W-1]}}, y_q};
	end

	// delay words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SECTION_COUNT; i++) begin
				w1_q[i] <= '0;
				w2_q[i] <= '0;
			end
		end else begin
			if (w1_en) w1_q[sec_q] <= sat_state(add_res);
			if (w2_en) w2_q[sec_q] <= sat_state(add_res);
		end
	end

	// ---------------- output ----------------
	assign sum_shift = sum_q >>> OSH;
	assign sum_top   = sum_shift[SUM_W-1:SAMPLE_BITS-1];

	always_comb begin
		if (sum_top == '0 || sum_top == '1) begin
			out_sat = sum_shift[SAMPLE_BITS-1:0];
		end else if (sum_shift[SUM_W-1]) begin
			out_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			out_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= out_sat;
			out_last_q <= last_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = DATA_W'(out_data_q);
	assign m_tlast  = out_last_q;

	// ---------------- checks ----------------
	a_start_first_section: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_B0) && (sec_q == '0))
		else $error("sequencer did not start at the first section");

	a_last_section_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) && (sec_q == SEC_W'(SECTION_COUNT - 1)) |=> state_q == ST_DONE)
		else $error("sequencer ran past the last section");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_DONE)
		else $error("result beat raised outside the output step");

	a_no_input_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_tready)
		else $error("input taken while a sample is in work");

endmodule
